[hdl/rlb_pkg.sv]
// ---------------------------------------------------------------------------
// rlb_pkg: shared types and helpers for the RGB layer blend unit
// Pixel request types, mode and register codes, divide-by-255 rounding.
// ---------------------------------------------------------------------------
package rlb_pkg;

    localparam int NUM_LANES = 3;

    // blend_mode codes
    localparam logic [2:0] MODE_MULTIPLY = 3'd0;
    localparam logic [2:0] MODE_SUBTRACT = 3'd1;
    localparam logic [2:0] MODE_OVERLAY  = 3'd2;
    localparam logic [2:0] MODE_SCREEN   = 3'd3;
    localparam logic [2:0] MODE_ADD      = 3'd4;
    localparam logic [2:0] MODE_SCALE    = 3'd5;

    // configuration register indexes
    localparam logic [1:0] REG_BLEND_MODE     = 2'd0;
    localparam logic [1:0] REG_CHANNEL_SELECT = 2'd1;
    localparam logic [1:0] REG_CHANNEL_AMOUNT = 2'd2;

    typedef struct packed {
        logic [7:0] top_blue;
        logic [7:0] top_green;
        logic [7:0] top_red;
        logic [7:0] bottom_blue;
        logic [7:0] bottom_green;
        logic [7:0] bottom_red;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
    } pix_out_t;

    // per-lane findings handed to the merge stage
    typedef struct packed {
        logic [7:0] blend;
        logic [7:0] chan;
    } lane_res_t;

    // round(x/255), half up; exact for x up to 65152
    function automatic logic [7:0] div255_round(input logic [16:0] x);
        logic [16:0] y;
        logic [16:0] z;
        begin
            y = x + 17'd128;
            z = y + {8'd0, y[16:8]};
            return z[15:8];
        end
    endfunction

endpackage

[hdl/rlb_lane.sv]
// ---------------------------------------------------------------------------
// rlb_lane: one colour channel of the blender
// Registers one 8x8 product per request, then finishes every mode's value.
// ---------------------------------------------------------------------------
module rlb_lane
    import rlb_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [7:0]        t,
    input  logic [7:0]        b,
    input  logic [2:0]        mode,
    input  logic signed [8:0] amount,
    output lane_res_t         res
);

    logic        inv;
    logic [7:0]  op_a;
    logic [7:0]  op_b;
    logic [15:0] prod_next;

    logic [15:0] prod_reg;
    logic [7:0]  t_reg;
    logic [7:0]  b_reg;
    logic        inv_reg;

    logic [16:0]       x;
    logic [7:0]        q;
    logic signed [9:0] sum;

    // screen, and overlay on a light bottom, work on the complements
    always_comb
    begin
        inv = (mode == MODE_SCREEN) || ((mode == MODE_OVERLAY) && b[7]);
        if (mode == MODE_SCALE)
        begin
            op_a = t;
            op_b = amount[8] ? 8'd0 : amount[7:0];
        end
        else if (inv)
        begin
            op_a = ~t;
            op_b = ~b;
        end
        else
        begin
            op_a = t;
            op_b = b;
        end
        prod_next = {8'd0, op_a} * {8'd0, op_b};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            t_reg    <= t;
            b_reg    <= b;
            inv_reg  <= inv;
        end
    end

    always_comb
    begin
        x   = (mode == MODE_OVERLAY) ? {prod_reg, 1'b0} : {1'b0, prod_reg};
        q   = div255_round(x);
        sum = $signed({2'b00, t_reg}) + $signed({amount[8], amount});

        case (mode)
            MODE_MULTIPLY: res.blend = q;
            MODE_SUBTRACT: res.blend = (t_reg > b_reg) ? (t_reg - b_reg) : 8'd0;
            MODE_OVERLAY:  res.blend = inv_reg ? ~q : q;
            MODE_SCREEN:   res.blend = ~q;
            default:       res.blend = t_reg;
        endcase

        case (mode)
            MODE_ADD:
            begin
                if (sum[9])
                    res.chan = 8'd0;
                else if (sum[8])
                    res.chan = 8'hFF;
                else
                    res.chan = sum[7:0];
            end
            MODE_SCALE: res.chan = (prod_reg[15:8] != 8'd0) ? 8'hFF : prod_reg[7:0];
            default:    res.chan = t_reg;
        endcase
    end

endmodule

[hdl/rlb_merge.sv]
// ---------------------------------------------------------------------------
// rlb_merge: merges the lane findings into the output pixel register
// Picks the per-channel value or the blend value for each channel.
// ---------------------------------------------------------------------------
module rlb_merge
    import rlb_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  lane_res_t  res [NUM_LANES],
    input  logic [2:0] mode,
    input  logic [1:0] chan_sel,
    output pix_out_t   pix
);

    logic [7:0] val [NUM_LANES];
    logic       chan_mode;
    pix_out_t   pix_next;
    pix_out_t   pix_reg;

    always_comb
    begin
        chan_mode = (mode == MODE_ADD) || (mode == MODE_SCALE);
        for (int i = 0; i < NUM_LANES; i++)
        begin
            val[i] = (chan_mode && (chan_sel == 2'(i))) ? res[i].chan : res[i].blend;
        end
        pix_next.out_blue  = val[0];
        pix_next.out_green = val[1];
        pix_next.out_red   = val[2];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pix_reg <= pix_next;
    end

    assign pix = pix_reg;

endmodule

[hdl/rgb_layer_blend_unit.sv]
// ---------------------------------------------------------------------------
// rgb_layer_blend_unit: two-layer BGR pixel blender
// Multiply, subtract, overlay and screen blends, plus single channel add/scale.
// ---------------------------------------------------------------------------
// Takes one top/bottom pixel pair per clock and returns one blended pixel per
// clock while the output side is ready; a request passes the lane product
// register, then the merge output register. Each of three channel lanes holds
// one 8x8 multiplier whose registered product feeds a combinational
// divide-by-255. Registers may be written only while no request is in flight; they take effect at once.
module rgb_layer_blend_unit
    import rlb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  pix_in_t    in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output pix_out_t   out_data,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [8:0] cfg_data
);

    logic [2:0]        blend_mode_reg;
    logic [1:0]        channel_select_reg;
    logic signed [8:0] channel_amount_reg;

    logic s1_valid_reg;
    logic out_valid_reg;
    logic adv1;
    logic adv2;

    logic [7:0] top_ch [NUM_LANES];
    logic [7:0] bot_ch [NUM_LANES];
    lane_res_t  res    [NUM_LANES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_mode_reg     <= MODE_MULTIPLY;
            channel_select_reg <= 2'd0;
            channel_amount_reg <= 9'sd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BLEND_MODE:     blend_mode_reg     <= cfg_data[2:0];
                REG_CHANNEL_SELECT: channel_select_reg <= cfg_data[1:0];
                REG_CHANNEL_AMOUNT: channel_amount_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // advance the output register when empty or drained, stage one behind it
    assign adv2     = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || adv2;
    assign adv1     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (adv2)
                out_valid_reg <= s1_valid_reg;
        end
    end

    assign top_ch[0] = in_data.top_blue;
    assign top_ch[1] = in_data.top_green;
    assign top_ch[2] = in_data.top_red;
    assign bot_ch[0] = in_data.bottom_blue;
    assign bot_ch[1] = in_data.bottom_green;
    assign bot_ch[2] = in_data.bottom_red;

    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        rlb_lane u_lane (
            .clk    (clk),
            .en     (adv1),
            .t      (top_ch[g]),
            .b      (bot_ch[g]),
            .mode   (blend_mode_reg),
            .amount (channel_amount_reg),
            .res    (res[g])
        );
    end

    rlb_merge u_merge (
        .clk      (clk),
        .en       (adv2 && s1_valid_reg),
        .res      (res),
        .mode     (blend_mode_reg),
        .chan_sel (channel_select_reg),
        .pix      (out_data)
    );

    assign out_valid = out_valid_reg;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> s1_valid_reg)
        else $error("accepted request did not enter stage one");

    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && adv2 |=> out_valid_reg)
        else $error("stage one request lost on its way to the output");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready && s1_valid_reg |-> !in_ready)
        else $error("request taken while the pipeline is full and stalled");

endmodule
